/* sv/websocket_masked_frame_writer_defines.svh */
// Assertion helpers for the masked frame writer.
`ifndef WEBSOCKET_MASKED_FRAME_WRITER_DEFINES_SVH
`define WEBSOCKET_MASKED_FRAME_WRITER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define WSMFW_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define WSMFW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define WSMFW_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define WSMFW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

/* sv/wsmfw_pkg.sv */
package wsmfw_pkg;

  // Input word kinds, carried on in_tuser.
  typedef enum logic [0:0] {
    OP_START = 1'b0,
    OP_DATA  = 1'b1
  } wsmfw_op_t;

  localparam int unsigned LEN_W   = 32;
  localparam int unsigned KEY_W   = 32;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned IDX_W   = 4;   // header byte index, up to 14 bytes

  localparam logic [BYTE_W-1:0] HDR_FIN_BINARY = 8'h82;
  localparam logic [BYTE_W-1:0] HDR_MASK_BIT   = 8'h80;
  localparam logic [BYTE_W-1:0] LEN_CODE_16    = 8'd126;
  localparam logic [BYTE_W-1:0] LEN_CODE_64    = 8'd127;
  localparam logic [LEN_W-1:0]  LEN_MAX_16     = 32'd65535;

  localparam logic [IDX_W-1:0]  HDR_LEN_SHORT  = 4'd6;
  localparam logic [IDX_W-1:0]  HDR_LEN_MED    = 4'd8;
  localparam logic [IDX_W-1:0]  HDR_LEN_LONG   = 4'd14;

  // One header byte and whether it closes the header.
  typedef struct packed {
    logic [BYTE_W-1:0] value;
    logic              last;
  } wsmfw_hdr_t;

endpackage

/* sv/wsmfw_hdr_gen.sv */
module wsmfw_hdr_gen
  import wsmfw_pkg::*;
(
  input  logic [LEN_W-1:0] len,
  input  logic [KEY_W-1:0] key,
  input  logic [IDX_W-1:0] idx,
  output wsmfw_hdr_t       hdr
);

  typedef enum logic [1:0] {
    CLS_SHORT,
    CLS_MED,
    CLS_LONG
  } len_cls_t;

  len_cls_t          cls;
  logic [IDX_W-1:0]  hdr_len;
  logic [IDX_W-1:0]  key_base;
  logic [1:0]        key_off;
  logic [BYTE_W-1:0] key_byte;
  logic [BYTE_W-1:0] len_code;

  always_comb begin
    if (len < LEN_W'(LEN_CODE_16)) begin
      cls = CLS_SHORT;
    end else if (len <= LEN_MAX_16) begin
      cls = CLS_MED;
    end else begin
      cls = CLS_LONG;
    end
  end

  always_comb begin
    unique case (cls)
      CLS_SHORT: begin
        hdr_len  = HDR_LEN_SHORT;
        len_code = {1'b0, len[6:0]};
      end
      CLS_MED: begin
        hdr_len  = HDR_LEN_MED;
        len_code = LEN_CODE_16;
      end
      default: begin
        hdr_len  = HDR_LEN_LONG;
        len_code = LEN_CODE_64;
      end
    endcase
    key_base = hdr_len - IDX_W'(4);
    key_off  = idx[1:0] - key_base[1:0];
  end

  // Key bytes go out most significant first.
  always_comb begin
    unique case (key_off)
      2'd0:    key_byte = key[31:24];
      2'd1:    key_byte = key[23:16];
      2'd2:    key_byte = key[15:8];
      default: key_byte = key[7:0];
    endcase
  end

  always_comb begin
    hdr.last = (idx == hdr_len - IDX_W'(1));
    if (idx == '0) begin
      hdr.value = HDR_FIN_BINARY;
    end else if (idx == IDX_W'(1)) begin
      hdr.value = HDR_MASK_BIT | len_code;
    end else if (idx >= key_base) begin
      hdr.value = key_byte;
    end else if (cls == CLS_MED) begin
      hdr.value = (idx == IDX_W'(2)) ? len[15:8] : len[7:0];
    end else begin
      // extended 64-bit length: four zero bytes, then the 32-bit length
      unique case (idx)
        IDX_W'(6): hdr.value = len[31:24];
        IDX_W'(7): hdr.value = len[23:16];
        IDX_W'(8): hdr.value = len[15:8];
        IDX_W'(9): hdr.value = len[7:0];
        default:   hdr.value = '0;
      endcase
    end
  end

endmodule

/* sv/websocket_masked_frame_writer.sv */
// Client-side WebSocket masked binary frame writer.
// Input channel (in_*): in_tuser selects the word kind. A start word carries
// the payload length and the 32-bit masking key and opens a frame; the block
// then sends 0x82, the masked length byte (plus 2 or 8 extended length bytes)
// and the four key bytes: 6, 8 or 14 output words. A data word carries one
// payload byte, sent XORed with key byte (payload index mod 4). A data word
// with no frame open yields one word with error set and zero data.
// Output channel (out_*): one frame byte per word; out_tlast marks the last
// word caused by one input word, out_tuser[0] the byte that completes the
// frame, out_tuser[1] the error word.
// An accepted word is held in the working register, and its output words are
// registered in the output register from there.
// Throughput: data words pass one per cycle while out_tready is high; a start
// word occupies the working register until its last header byte is loaded,
// one header byte per cycle likewise, and in_tready stays low meanwhile.
// Reset (synchronous, rst_n low) closes any frame and empties both registers.
// When out_tready is low and the output register is full, it holds and the working
// register stalls; in_tready then drops until the held word has finished.
module websocket_masked_frame_writer
  import wsmfw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // [31:0] frame_length, [63:32] mask_key, [71:64] data_byte
  input  logic [0:0]  in_tuser,   // [0] opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_byte
  output logic        out_tlast,  // run_last
  output logic [1:0]  out_tuser   // [0] frame_end, [1] error
);

`include "websocket_masked_frame_writer_defines.svh"

  // working register
  logic              hold_valid_r, hold_valid_nxt;
  wsmfw_op_t         hold_op_r;
  logic [LEN_W-1:0]  hold_len_r;
  logic [KEY_W-1:0]  hold_key_r;
  logic [BYTE_W-1:0] hold_data_r;
  logic [IDX_W-1:0]  idx_r, idx_nxt;

  // frame state
  logic [LEN_W-1:0]  bytes_left_r, bytes_left_nxt;
  logic [KEY_W-1:0]  key_store_r, key_store_nxt;
  logic [1:0]        key_index_r, key_index_nxt;
  logic              frame_open_r, frame_open_nxt;

  // output register
  logic              out_valid_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_last_r;
  logic              out_fend_r;
  logic              out_err_r;

  wsmfw_hdr_t        hdr;
  logic [BYTE_W-1:0] key_byte;
  logic [BYTE_W-1:0] cur_byte;
  logic              cur_last;
  logic              cur_fend;
  logic              cur_err;
  logic              out_load;
  logic              in_accept;

  wsmfw_hdr_gen u_hdr_gen (
    .len (hold_len_r),
    .key (hold_key_r),
    .idx (idx_r),
    .hdr (hdr)
  );

  // Load the output register from the held word whenever it is empty or being drained.
  assign out_load  = hold_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !hold_valid_r || (out_load && cur_last);
  assign in_accept = in_tvalid && in_tready;

  always_comb begin
    unique case (key_index_r)
      2'd0:    key_byte = key_store_r[31:24];
      2'd1:    key_byte = key_store_r[23:16];
      2'd2:    key_byte = key_store_r[15:8];
      default: key_byte = key_store_r[7:0];
    endcase
  end

  // Pick the next wire byte for the held word.
  always_comb begin
    if (hold_op_r == OP_START) begin
      cur_byte = hdr.value;
      cur_last = hdr.last;
      cur_fend = hdr.last && (hold_len_r == '0);
      cur_err  = 1'b0;
    end else if (!frame_open_r) begin
      cur_byte = '0;
      cur_last = 1'b1;
      cur_fend = 1'b0;
      cur_err  = 1'b1;
    end else begin
      cur_byte = hold_data_r ^ key_byte;
      cur_last = 1'b1;
      cur_fend = (bytes_left_r == LEN_W'(1));
      cur_err  = 1'b0;
    end
  end

  // Advance frame state once the held word is done.
  always_comb begin
    bytes_left_nxt = bytes_left_r;
    key_store_nxt  = key_store_r;
    key_index_nxt  = key_index_r;
    frame_open_nxt = frame_open_r;
    if (out_load && cur_last) begin
      if (hold_op_r == OP_START) begin
        bytes_left_nxt = hold_len_r;
        key_store_nxt  = hold_key_r;
        key_index_nxt  = '0;
        frame_open_nxt = (hold_len_r != '0);
      end else if (frame_open_r) begin
        bytes_left_nxt = bytes_left_r - LEN_W'(1);
        key_index_nxt  = key_index_r + 2'd1;
        frame_open_nxt = !cur_fend;
      end
    end
  end

  always_comb begin
    idx_nxt        = idx_r;
    hold_valid_nxt = hold_valid_r;
    if (out_load) begin
      idx_nxt = cur_last ? '0 : idx_r + IDX_W'(1);
      if (cur_last) begin
        hold_valid_nxt = 1'b0;
      end
    end
    if (in_accept) begin
      hold_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
      idx_r        <= '0;
      bytes_left_r <= '0;
      key_store_r  <= '0;
      key_index_r  <= '0;
      frame_open_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
      idx_r        <= idx_nxt;
      bytes_left_r <= bytes_left_nxt;
      key_store_r  <= key_store_nxt;
      key_index_r  <= key_index_nxt;
      frame_open_r <= frame_open_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_accept) begin
      hold_op_r   <= wsmfw_op_t'(in_tuser[0]);
      hold_len_r  <= in_tdata[31:0];
      hold_key_r  <= in_tdata[63:32];
      hold_data_r <= in_tdata[71:64];
    end
    if (out_load) begin
      out_byte_r <= cur_byte;
      out_last_r <= cur_last;
      out_fend_r <= cur_fend;
      out_err_r  <= cur_err;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = {out_err_r, out_fend_r};

  `WSMFW_ASSERT_SAME(a_err_word_shape, clk, rst_n, out_tvalid && out_tuser[1],
    out_tdata == 8'h00 && out_tlast && !out_tuser[0], "error word malformed")
  `WSMFW_ASSERT_SAME(a_fend_is_last, clk, rst_n, out_tvalid && out_tuser[0],
    out_tlast, "frame end without last")
  `WSMFW_ASSERT_SAME(a_idx_in_range, clk, rst_n, hold_valid_r,
    idx_r < HDR_LEN_LONG, "header index out of range")
  `WSMFW_ASSERT_NEXT(a_fend_closes, clk, rst_n, out_load && cur_fend,
    !frame_open_r, "frame still open after frame end")
  `WSMFW_ASSERT_SAME(a_ready_when_busy, clk, rst_n, in_tready && hold_valid_r,
    out_load && cur_last, "accepting while working word unfinished")

endmodule
